// File: rtl/char_lcd_bus_sequencer_top_defines.svh
// assertion macros for the character lcd bus sequencer
`ifndef CHAR_LCD_BUS_SEQUENCER_TOP_DEFINES_SVH
`define CHAR_LCD_BUS_SEQUENCER_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define CLBS_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication, checked out of reset
`define CLBS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// File: rtl/clbs_pkg.sv
// shared types, phase codes and helpers for the character lcd bus sequencer
package clbs_pkg;

    localparam int TickW = 26;

    // sequencer phases
    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_RD_E     = 3'd1;
    localparam logic [2:0] PH_RD_GAP   = 3'd2;
    localparam logic [2:0] PH_RDY_WAIT = 3'd3;
    localparam logic [2:0] PH_WR_E     = 3'd4;
    localparam logic [2:0] PH_WR_HOLD  = 3'd5;
    localparam logic [2:0] PH_POST     = 3'd6;

    // input function codes
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_INIT  = 2'd1;
    localparam logic [1:0] FUNC_WRITE = 2'd2;
    localparam logic [1:0] FUNC_GOTO  = 2'd3;

    // register indexes
    localparam logic [1:0] REG_TPQ   = 2'd0;
    localparam logic [1:0] REG_CMD   = 2'd1;
    localparam logic [1:0] REG_RDY   = 2'd2;
    localparam logic [1:0] REG_CLEAR = 2'd3;

    localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
    localparam logic [7:0] ROW2_OFFSET   = 8'h40;

    typedef struct packed {
        logic [7:0]  tpq;
        logic [9:0]  cmd_us;
        logic [9:0]  rdy_us;
        logic [15:0] clear_us;
    } cfg_t;

    // lowest bit is e, matching the result tdata layout
    typedef struct packed {
        logic       ready;
        logic       drive;
        logic [7:0] bus;
        logic       rw;
        logic       rs;
        logic       e;
    } res_t;

    typedef struct packed {
        logic [2:0] phase;
        logic [2:0] init_step;
    } stat_t;

    // init command bytes: display on, 8-bit two-line, clear, entry mode
    function automatic logic [7:0] init_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h0C;
            2'd1:    b = 8'h38;
            2'd2:    b = 8'h01;
            default: b = 8'h06;
        endcase
        return b;
    endfunction

    // microseconds to clock ticks: us * 4 * ticks per quarter microsecond
    function automatic logic [TickW-1:0] us_to_ticks(input logic [15:0] us,
                                                     input logic [7:0] tpq);
        logic [23:0] prod;
        prod = 24'(us) * 24'(tpq);
        return {prod, 2'b00};
    endfunction

endpackage

// File: rtl/char_lcd_bus_sequencer_top.sv
// top level of the character lcd bus sequencer with stream ports and apb settings
//
// Each input transfer is one clock tick of the display sequencer (tuser 0) or a command
// (1 init, 2 write character, 3 goto column/row) and yields exactly one result transfer
// with the pin levels after that tick. The block takes one transfer per clock: the phase
// state is updated and the result is registered at the accepting edge, and the result
// register frees itself in the same cycle it is taken, so s_tready stays high unless a
// result is held back by m_tready. Commands that arrive while a sequence is running are
// ignored; ready_res in the result says when the next one is taken. Timing values follow
// the settings registers, converted with one multiply in the phase update path.
`include "char_lcd_bus_sequencer_top_defines.svh"

module char_lcd_bus_sequencer_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] char_code, [13:8] column, [15:14] row, [23:16] bus_in
    input  logic [23:0] s_tdata,
    // [1:0] func
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] pin_e, [1] pin_rs, [2] pin_rw, [10:3] bus_out, [11] bus_drive, [12] ready_res
    output logic [15:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    clbs_pkg::cfg_t  cfg;
    clbs_pkg::res_t  res_next;
    clbs_pkg::stat_t stat;
    clbs_pkg::res_t  res_reg;
    logic            m_valid_reg, m_valid_next;
    logic            s_accept;

    clbs_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    clbs_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (s_accept),
        .func      (s_tuser),
        .char_code (s_tdata[7:0]),
        .column    (s_tdata[13:8]),
        .row       (s_tdata[15:14]),
        .bus_in    (s_tdata[23:16]),
        .cfg       (cfg),
        .res_next  (res_next),
        .stat      (stat)
    );

    assign s_tready     = !m_valid_reg || m_tready;
    assign s_accept     = s_tvalid && s_tready;
    assign m_valid_next = s_accept || (m_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, res_reg};

    `CLBS_ASSERT_NEXT(a_accept_gives_result, aclk, aresetn, s_accept, m_valid_reg)
    `CLBS_ASSERT_NOW(a_idle_no_init, aclk, aresetn, stat.init_step != 3'd0,
                     stat.phase != clbs_pkg::PH_IDLE)
    `CLBS_ASSERT_NOW(a_ready_e_low, aclk, aresetn, m_valid_reg && res_reg.ready, !res_reg.e)
    `CLBS_ASSERT_NOW(a_e_in_strobe, aclk, aresetn, res_next.e,
                     stat.phase == clbs_pkg::PH_RD_E || stat.phase == clbs_pkg::PH_WR_E ||
                     stat.phase == clbs_pkg::PH_IDLE || stat.phase == clbs_pkg::PH_RD_GAP ||
                     stat.phase == clbs_pkg::PH_RDY_WAIT || stat.phase == clbs_pkg::PH_POST)

endmodule

// File: rtl/clbs_apb_regs.sv
// apb register file holding the timing settings
module clbs_apb_regs (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output clbs_pkg::cfg_t      cfg
);

    logic [7:0]  tpq_reg;
    logic [9:0]  cmd_reg;
    logic [9:0]  rdy_reg;
    logic [15:0] clear_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tpq_reg   <= 8'd42;
            cmd_reg   <= 10'd39;
            rdy_reg   <= 10'd8;
            clear_reg <= 16'd2000;
        end else if (wr_en) begin
            case (paddr[3:2])
                clbs_pkg::REG_TPQ:   tpq_reg   <= pwdata[7:0];
                clbs_pkg::REG_CMD:   cmd_reg   <= pwdata[9:0];
                clbs_pkg::REG_RDY:   rdy_reg   <= pwdata[9:0];
                clbs_pkg::REG_CLEAR: clear_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            clbs_pkg::REG_TPQ:   prdata = {24'd0, tpq_reg};
            clbs_pkg::REG_CMD:   prdata = {22'd0, cmd_reg};
            clbs_pkg::REG_RDY:   prdata = {22'd0, rdy_reg};
            clbs_pkg::REG_CLEAR: prdata = {16'd0, clear_reg};
            default:             prdata = 32'd0;
        endcase
    end

    assign cfg = '{tpq: tpq_reg, cmd_us: cmd_reg, rdy_us: rdy_reg, clear_us: clear_reg};

endmodule

// File: rtl/clbs_core.sv
// phase sequencer: busy poll, byte strobe and post-write waits
module clbs_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step_en,
    input  logic [1:0]         func,
    input  logic [7:0]         char_code,
    input  logic [5:0]         column,
    input  logic [1:0]         row,
    input  logic [7:0]         bus_in,
    input  clbs_pkg::cfg_t     cfg,
    output clbs_pkg::res_t     res_next,
    output clbs_pkg::stat_t    stat
);

    logic [2:0]                 phase_reg, phase_next;
    logic [2:0]                 init_reg, init_next;
    logic [clbs_pkg::TickW-1:0] tick_reg, tick_next;
    logic [7:0]                 pbyte_reg, pbyte_next;
    logic                       pdata_reg, pdata_next;
    logic                       e_reg, e_next;
    logic                       rs_reg, rs_next;
    logic                       rw_reg, rw_next;
    logic                       drive_reg, drive_next;
    logic [7:0]                 bus_reg, bus_next;

    logic [15:0]                wait_us;
    logic [clbs_pkg::TickW-1:0] wait_ticks;
    logic [clbs_pkg::TickW-1:0] quarter_ticks;
    logic [clbs_pkg::TickW-1:0] read_ticks;
    logic [7:0]                 goto_addr;

    assign quarter_ticks = clbs_pkg::TickW'(cfg.tpq);
    assign read_ticks    = clbs_pkg::TickW'({cfg.tpq, 1'b0});

    // one shared multiply serves the ready wait and every post wait
    always_comb begin
        if (phase_reg == clbs_pkg::PH_RD_E) begin
            wait_us = {6'd0, cfg.rdy_us};
        end else if (init_reg == 3'd3) begin
            wait_us = cfg.clear_us;
        end else if (init_reg != 3'd0 || pdata_reg) begin
            wait_us = {6'd0, cfg.cmd_us};
        end else begin
            wait_us = 16'd0;
        end
    end

    assign wait_ticks = clbs_pkg::us_to_ticks(wait_us, cfg.tpq);

    always_comb begin
        goto_addr = {2'b00, column} - 8'd1;
        if (row != 2'd1) begin
            goto_addr = goto_addr | clbs_pkg::ROW2_OFFSET;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        init_next  = init_reg;
        tick_next  = tick_reg;
        pbyte_next = pbyte_reg;
        pdata_next = pdata_reg;
        e_next     = e_reg;
        rs_next    = rs_reg;
        rw_next    = rw_reg;
        drive_next = drive_reg;
        bus_next   = bus_reg;

        if (phase_reg == clbs_pkg::PH_IDLE) begin
            if (func != clbs_pkg::FUNC_TICK) begin
                case (func)
                    clbs_pkg::FUNC_INIT: begin
                        init_next  = 3'd1;
                        pbyte_next = clbs_pkg::init_byte(2'd0);
                        pdata_next = 1'b0;
                    end
                    clbs_pkg::FUNC_WRITE: begin
                        init_next  = 3'd0;
                        pbyte_next = char_code;
                        pdata_next = 1'b1;
                    end
                    default: begin
                        init_next  = 3'd0;
                        pbyte_next = clbs_pkg::CMD_SET_DDRAM | goto_addr;
                        pdata_next = 1'b0;
                    end
                endcase
                phase_next = clbs_pkg::PH_RD_E;
                tick_next  = read_ticks;
                drive_next = 1'b0;
                rw_next    = 1'b1;
                rs_next    = 1'b0;
                e_next     = 1'b1;
            end
        end else if (tick_reg > clbs_pkg::TickW'(1)) begin
            tick_next = tick_reg - clbs_pkg::TickW'(1);
        end else begin
            case (phase_reg)
                clbs_pkg::PH_RD_E: begin
                    e_next = 1'b0;
                    // bit 7 is the busy flag
                    if (bus_in[7]) begin
                        phase_next = clbs_pkg::PH_RD_GAP;
                        tick_next  = quarter_ticks;
                    end else begin
                        drive_next = 1'b1;
                        phase_next = clbs_pkg::PH_RDY_WAIT;
                        tick_next  = wait_ticks;
                    end
                end
                clbs_pkg::PH_RD_GAP: begin
                    phase_next = clbs_pkg::PH_RD_E;
                    tick_next  = read_ticks;
                    drive_next = 1'b0;
                    rw_next    = 1'b1;
                    rs_next    = 1'b0;
                    e_next     = 1'b1;
                end
                clbs_pkg::PH_RDY_WAIT: begin
                    rw_next    = 1'b0;
                    rs_next    = pdata_reg;
                    drive_next = 1'b1;
                    bus_next   = pbyte_reg;
                    e_next     = 1'b1;
                    phase_next = clbs_pkg::PH_WR_E;
                    tick_next  = quarter_ticks;
                end
                clbs_pkg::PH_WR_E: begin
                    e_next     = 1'b0;
                    phase_next = clbs_pkg::PH_WR_HOLD;
                    tick_next  = quarter_ticks;
                end
                clbs_pkg::PH_WR_HOLD: begin
                    phase_next = clbs_pkg::PH_POST;
                    tick_next  = wait_ticks;
                end
                clbs_pkg::PH_POST: begin
                    if (init_reg >= 3'd1 && init_reg <= 3'd3) begin
                        // next init command, then poll busy again
                        pbyte_next = clbs_pkg::init_byte(init_reg[1:0]);
                        pdata_next = 1'b0;
                        init_next  = init_reg + 3'd1;
                        phase_next = clbs_pkg::PH_RD_E;
                        tick_next  = read_ticks;
                        drive_next = 1'b0;
                        rw_next    = 1'b1;
                        rs_next    = 1'b0;
                        e_next     = 1'b1;
                    end else begin
                        init_next  = 3'd0;
                        phase_next = clbs_pkg::PH_IDLE;
                        tick_next  = '0;
                    end
                end
                default: begin
                    phase_next = clbs_pkg::PH_IDLE;
                    init_next  = 3'd0;
                    tick_next  = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= clbs_pkg::PH_IDLE;
            init_reg  <= 3'd0;
            tick_reg  <= '0;
            pbyte_reg <= 8'd0;
            pdata_reg <= 1'b0;
            e_reg     <= 1'b0;
            rs_reg    <= 1'b0;
            rw_reg    <= 1'b0;
            drive_reg <= 1'b0;
            bus_reg   <= 8'd0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            init_reg  <= init_next;
            tick_reg  <= tick_next;
            pbyte_reg <= pbyte_next;
            pdata_reg <= pdata_next;
            e_reg     <= e_next;
            rs_reg    <= rs_next;
            rw_reg    <= rw_next;
            drive_reg <= drive_next;
            bus_reg   <= bus_next;
        end
    end

    assign res_next = '{ready: (phase_next == clbs_pkg::PH_IDLE), drive: drive_next,
                        bus: bus_next, rw: rw_next, rs: rs_next, e: e_next};
    assign stat = '{phase: phase_reg, init_step: init_reg};

endmodule
